/* src/ogtd_pkg.sv */
// Shared types, constants and helper functions for the oversampled GCR telemetry decoder.
package ogtd_pkg;

    // Field widths
    localparam int WORD_W     = 32;
    localparam int VALUE_W    = 12;
    localparam int SHIFT_W    = 20;
    localparam int CNT_W      = 7;
    localparam int BIT_CNT_W  = 6;
    localparam int FRAME_BITS = 21;

    // Defaults for the top-level parameters
    localparam int OVERSAMPLE_DEF  = 3;
    localparam int MAX_SAMPLES_DEF = 66;

    localparam logic [WORD_W-1:0] LINE_MASK_RST = 32'h0000_0001;

    // Input word: one sampled port word
    typedef struct packed {
        logic [WORD_W-1:0] sample_word;
        logic              is_last;
    } t_in_word;

    // Output word: decoded payload or error
    typedef struct packed {
        logic [VALUE_W-1:0] telemetry_value;
        logic               frame_error;
    } t_out_word;

    // Shift in n bits (n >= 1): a one followed by n-1 zeros, MSB first
    function automatic logic [SHIFT_W-1:0] push_bits(input logic [SHIFT_W-1:0] sv,
                                                     input logic [CNT_W-1:0]   n);
        logic [SHIFT_W-1:0] v;
        v = sv << n;
        if ((n != '0) && (n <= CNT_W'(SHIFT_W))) begin
            v = v | (SHIFT_W'(1) << (n - CNT_W'(1)));
        end
        return v;
    endfunction

    // GCR quintet to nibble; codes that are not symbols give zero
    function automatic logic [3:0] gcr_nibble(input logic [4:0] q);
        logic [3:0] d;
        case (q)
            5'h09:   d = 4'h9;
            5'h0a:   d = 4'ha;
            5'h0b:   d = 4'hb;
            5'h0d:   d = 4'hd;
            5'h0e:   d = 4'he;
            5'h0f:   d = 4'hf;
            5'h12:   d = 4'h2;
            5'h13:   d = 4'h3;
            5'h15:   d = 4'h5;
            5'h16:   d = 4'h6;
            5'h17:   d = 4'h7;
            5'h1a:   d = 4'h8;
            5'h1b:   d = 4'h1;
            5'h1d:   d = 4'h4;
            5'h1e:   d = 4'hc;
            default: d = 4'h0;
        endcase
        return d;
    endfunction

endpackage

/* src/oversampled_gcr_telemetry_decoder.sv */
// Top level of the oversampled GCR telemetry decoder.
//
//  channel   direction  handshake                 payload
//  in        input      i_in_valid / o_in_ready   i_in_word  (t_in_word)
//  out       output     o_out_valid / i_out_ready o_out_word (t_out_word)
//  cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (line mask)
//
// One word per cycle while not stalled: a word is held in the input register, then
// the run tracker and, on the last word, the GCR decoder update the result register.
// A held result stalls the input register only when it carries a last word;
// other words keep flowing.
// Synchronous active-low reset clears the frame state and sets the mask to one.
module oversampled_gcr_telemetry_decoder
    import ogtd_pkg::*;
#(
    parameter int OVERSAMPLE  = OVERSAMPLE_DEF,
    parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_in_word          i_in_word,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_out_word         o_out_word,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [WORD_W-1:0] i_cfg_data
);

    localparam logic [CNT_W-1:0]     MaxSamples = CNT_W'(MAX_SAMPLES);
    localparam logic [CNT_W:0]       HalfOs     = (CNT_W+1)'(OVERSAMPLE / 2);
    // Reciprocal of the oversampling ratio, rounded up, scaled by 2^16
    localparam logic [16:0]          DivRecip   = 17'(((1 << 16) + OVERSAMPLE - 1) / OVERSAMPLE);
    localparam logic [BIT_CNT_W-1:0] FrameBits  = BIT_CNT_W'(FRAME_BITS);
    localparam logic [BIT_CNT_W:0]   BitsMax    = {1'b0, {BIT_CNT_W{1'b1}}};

    logic [WORD_W-1:0]    r_line_mask;
    logic                 r_in_valid;
    logic [WORD_W-1:0]    r_word;
    logic                 r_last;

    logic                 r_started;
    logic [WORD_W-1:0]    r_last_level;
    logic [CNT_W-1:0]     r_run_length;
    logic [CNT_W-1:0]     r_samples_used;
    logic [BIT_CNT_W-1:0] r_bit_count;
    logic [SHIFT_W-1:0]   r_shift_value;

    logic                 r_out_valid;
    t_out_word            r_out_word;

    logic                 advance;
    logic                 n_started;
    logic [WORD_W-1:0]    n_last_level;
    logic [CNT_W-1:0]     n_run_length;
    logic [CNT_W-1:0]     n_samples_used;
    logic [BIT_CNT_W-1:0] n_bit_count;
    logic [SHIFT_W-1:0]   n_shift_value;
    t_out_word            n_out_word;

    logic [CNT_W-1:0]     run_inc;
    logic [CNT_W:0]       run_sum;
    logic [CNT_W+17:0]    run_prod;
    logic [CNT_W-1:0]     run_bits;
    logic [BIT_CNT_W:0]   bit_sum;
    logic [SHIFT_W-1:0]   padded;
    logic [BIT_CNT_W-1:0] pad;
    logic [15:0]          digits;
    logic [7:0]           cs8;
    logic [3:0]           cs4;

    // Advance the held word unless a last word meets a stalled result
    assign advance     = r_in_valid && (!r_last || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_mask <= LINE_MASK_RST;
        end else if (i_cfg_valid) begin
            r_line_mask <= i_cfg_data;
        end
    end

    // Input register: masked word and last flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_word <= i_in_word.sample_word & r_line_mask;
            r_last <= i_in_word.is_last;
        end
    end

    // Track runs between level changes and build the shift value
    always_comb begin
        n_started      = r_started;
        n_last_level   = r_last_level;
        n_run_length   = r_run_length;
        n_samples_used = r_samples_used;
        n_bit_count    = r_bit_count;
        n_shift_value  = r_shift_value;
        run_inc        = r_run_length + CNT_W'(1);
        // Round the run length to bits with a reciprocal multiply
        run_sum        = {1'b0, run_inc} + HalfOs;
        run_prod       = {{17{1'b0}}, run_sum} * {{(CNT_W+1){1'b0}}, DivRecip};
        run_bits       = run_prod[CNT_W+15:16];
        bit_sum        = {1'b0, r_bit_count} + {1'b0, run_bits[BIT_CNT_W-1:0]};
        if (run_bits > CNT_W'(BitsMax)) begin
            bit_sum = BitsMax;
        end
        if (!r_started) begin
            if (r_word == '0) begin
                n_started      = 1'b1;
                n_last_level   = '0;
                n_run_length   = '0;
                n_samples_used = CNT_W'(1);
            end
        end else if (r_samples_used < MaxSamples) begin
            n_samples_used = r_samples_used + CNT_W'(1);
            n_run_length   = run_inc;
            if (r_word != r_last_level) begin
                if (run_bits != '0) begin
                    n_shift_value = push_bits(r_shift_value, run_bits);
                    n_bit_count   = (bit_sum > BitsMax) ? BitsMax[BIT_CNT_W-1:0]
                                                        : bit_sum[BIT_CNT_W-1:0];
                end
                n_last_level = r_word;
                n_run_length = '0;
            end
        end
    end

    // Pad to a full frame, decode four quintets and check the nibble xor
    always_comb begin
        pad    = FrameBits - n_bit_count;
        padded = n_shift_value;
        if (pad != '0) begin
            padded = push_bits(n_shift_value, CNT_W'(pad));
        end
        digits = {gcr_nibble(padded[19:15]), gcr_nibble(padded[14:10]),
                  gcr_nibble(padded[9:5]), gcr_nibble(padded[4:0])};
        cs8    = digits[7:0] ^ digits[15:8];
        cs4    = cs8[3:0] ^ cs8[7:4];
        n_out_word.telemetry_value = '0;
        n_out_word.frame_error     = 1'b1;
        if ((n_bit_count <= FrameBits) && (cs4 == 4'hf)) begin
            n_out_word.telemetry_value = digits[15:4];
            n_out_word.frame_error     = 1'b0;
        end
    end

    // Frame state: update on each word, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started      <= 1'b0;
            r_last_level   <= '0;
            r_run_length   <= '0;
            r_samples_used <= '0;
            r_bit_count    <= '0;
            r_shift_value  <= '0;
        end else if (advance) begin
            if (r_last) begin
                r_started      <= 1'b0;
                r_last_level   <= '0;
                r_run_length   <= '0;
                r_samples_used <= '0;
                r_bit_count    <= '0;
                r_shift_value  <= '0;
            end else begin
                r_started      <= n_started;
                r_last_level   <= n_last_level;
                r_run_length   <= n_run_length;
                r_samples_used <= n_samples_used;
                r_bit_count    <= n_bit_count;
                r_shift_value  <= n_shift_value;
            end
        end
    end

    // Result register: load on a last word, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_out_word <= n_out_word;
        end
    end

endmodule
